/* rtl/tcr_pkg.sv */
// Shared types, constants and the color palette for the text mode renderer.
package tcr_pkg;

    localparam int MAX_ROWS   = 32;
    localparam int MAX_COLS   = 128;
    localparam int GLYPH_SIZE = 8;

    localparam int ROW_W      = 5;
    localparam int COL_W      = 7;
    localparam int CELL_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int CELL_AW    = $clog2(CELL_DEPTH);
    localparam int GLYPH_DEPTH = 256 * GLYPH_SIZE;
    localparam int GLYPH_AW   = $clog2(GLYPH_DEPTH);
    localparam int LINE_W     = $clog2(GLYPH_SIZE);

    // Register indexes of the configuration port
    localparam logic [1:0] CFG_ROWS = 2'd0;
    localparam logic [1:0] CFG_COLS = 2'd1;

    typedef enum logic [1:0] {
        FN_WRITE_CHAR = 2'd0,
        FN_SET_CURSOR = 2'd1,
        FN_LOAD_FONT  = 2'd2,
        FN_RENDER     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CELL,
        ST_GLYPH
    } state_t;

    typedef struct packed {
        logic               we;
        logic [CELL_AW-1:0] waddr;
        logic [15:0]        wdata;
        logic               re;
        logic [CELL_AW-1:0] raddr;
    } cell_req_t;

    typedef struct packed {
        logic                we;
        logic [GLYPH_AW-1:0] waddr;
        logic [7:0]          wdata;
        logic                re;
        logic [GLYPH_AW-1:0] raddr;
    } glyph_req_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // Fixed 16-entry palette
    function automatic rgb_t palette_rgb(input logic [3:0] colour);
        rgb_t c;
        case (colour)
            4'd0:    c = '{8'h00, 8'h00, 8'h00};
            4'd1:    c = '{8'h00, 8'h00, 8'haa};
            4'd2:    c = '{8'h00, 8'haa, 8'h00};
            4'd3:    c = '{8'h00, 8'haa, 8'haa};
            4'd4:    c = '{8'haa, 8'h00, 8'h00};
            4'd5:    c = '{8'haa, 8'h00, 8'haa};
            4'd6:    c = '{8'haa, 8'h55, 8'h00};
            4'd7:    c = '{8'haa, 8'haa, 8'haa};
            4'd8:    c = '{8'h55, 8'h55, 8'h55};
            4'd9:    c = '{8'h55, 8'h55, 8'hff};
            4'd10:   c = '{8'h55, 8'hff, 8'h55};
            4'd11:   c = '{8'h55, 8'hff, 8'hff};
            4'd12:   c = '{8'hff, 8'h55, 8'h55};
            4'd13:   c = '{8'hff, 8'h55, 8'hff};
            4'd14:   c = '{8'hff, 8'hff, 8'h55};
            default: c = '{8'hff, 8'hff, 8'hff};
        endcase
        return c;
    endfunction

endpackage

/* rtl/tcr_cell_store.sv */
// Character cell memory with a zero-fill sweep after reset.
module tcr_cell_store (
    input  logic                clk,
    input  logic                rst_n,
    input  tcr_pkg::cell_req_t  req,
    output logic [15:0]         rdata,
    output logic                busy
);
    import tcr_pkg::*;

    logic [15:0]        mem [CELL_DEPTH];
    logic [15:0]        rdata_reg;
    logic [CELL_AW-1:0] clr_cnt_reg;
    logic [CELL_AW-1:0] clr_cnt_next;
    logic               busy_reg;
    logic               busy_next;

    // Advance the clear sweep, one entry a cycle
    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        busy_next    = busy_reg;
        if (busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == CELL_AW'(CELL_DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            busy_reg    <= busy_next;
        end
    end

    // Write port: sweep has priority, no items arrive while it runs
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Registered read port, held when not enabled
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = busy_reg;

endmodule

/* rtl/tcr_glyph_store.sv */
// Font line memory, one write and one registered read port.
module tcr_glyph_store (
    input  logic                clk,
    input  tcr_pkg::glyph_req_t req,
    output logic [7:0]          rdata
);
    import tcr_pkg::*;

    logic [7:0] mem [GLYPH_DEPTH];
    logic [7:0] rdata_reg;

    // Store a font line
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Read a font line, hold when not enabled
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/tcr_pixel_out.sv */
// Palette lookup and output register for rendered pixel words.
module tcr_pixel_out (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  logic [3:0] colour,
    input  logic       out_stall,
    output logic       free,
    output logic       out_valid,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue
);
    import tcr_pkg::*;

    logic valid_reg;
    logic valid_next;
    rgb_t pix_reg;

    assign free = !valid_reg || !out_stall;

    // Hold the word until taken, replace it when loaded
    always_comb
    begin
        valid_next = valid_reg && out_stall;
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pix_reg <= palette_rgb(colour);
        end
    end

    assign out_valid = valid_reg;
    assign red       = pix_reg.r;
    assign green     = pix_reg.g;
    assign blue      = pix_reg.b;

endmodule

/* rtl/text_mode_character_renderer_core.sv */
// Write char, set cursor and load font complete when accepted and may follow back to back.
// Render pixel: cell read on acceptance, then glyph read in ST_CELL, then palette into the
// output register in ST_GLYPH. The input stalls until the render has loaded its word,
// so no new item is taken while a render is under way; a render waits if a word is unsent.
// Reset: async, active low; the cell memory is then zero-filled, during which no item is
// accepted (configuration writes are taken).
module text_mode_character_renderer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [15:0] char_word,
    input  logic [4:0]  cursor_row,
    input  logic [6:0]  cursor_col,
    input  logic [10:0] font_addr,
    input  logic [7:0]  font_byte,
    input  logic [9:0]  pixel_x,
    input  logic [7:0]  pixel_y,
    input  logic        cursor_on,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import tcr_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [5:0]        rows_reg;
    logic [7:0]        cols_reg;
    logic [ROW_W-1:0]  wr_row_reg;
    logic [ROW_W-1:0]  wr_row_next;
    logic [COL_W-1:0]  wr_col_reg;
    logic [COL_W-1:0]  wr_col_next;
    logic [LINE_W-1:0] px_lo_reg;
    logic [LINE_W-1:0] py_lo_reg;
    logic              cur_reg;
    logic              grid_reg;

    logic [ROW_W-1:0]  last_row;
    logic [COL_W-1:0]  last_col;
    logic [ROW_W-1:0]  cr;
    logic [COL_W-1:0]  cc;
    logic [ROW_W-1:0]  cy;
    logic [COL_W-1:0]  cx;
    logic              accept;
    logic              clearing;
    logic              out_free;
    logic              out_load;
    logic              glyph_bit;
    logic [3:0]        colour;
    logic [15:0]       cell_word;
    logic [7:0]        glyph_line;
    cell_req_t         cell_req;
    glyph_req_t        glyph_req;

    assign cfg_ready = 1'b1;
    assign in_stall  = clearing || (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;

    // Saturate the limits in use to 1..MAX, kept as last index
    always_comb
    begin
        if (rows_reg == '0)
            last_row = '0;
        else if (rows_reg > 6'(MAX_ROWS))
            last_row = ROW_W'(MAX_ROWS - 1);
        else
            last_row = ROW_W'(rows_reg - 6'd1);
        if (cols_reg == '0)
            last_col = '0;
        else if (cols_reg > 8'(MAX_COLS))
            last_col = COL_W'(MAX_COLS - 1);
        else
            last_col = COL_W'(cols_reg - 8'd1);
    end

    // Clamp the cursor and find the pixel's cell
    assign cr = (wr_row_reg > last_row) ? last_row : wr_row_reg;
    assign cc = (wr_col_reg > last_col) ? last_col : wr_col_reg;
    assign cx = pixel_x[9:LINE_W];
    assign cy = pixel_y[7:LINE_W];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= 6'd25;
            cols_reg <= 8'd80;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ROWS: rows_reg <= cfg_data[5:0];
                CFG_COLS: cols_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    // Sequencer, cursor update and memory requests
    always_comb
    begin
        state_next  = state_reg;
        wr_row_next = wr_row_reg;
        wr_col_next = wr_col_reg;
        out_load    = 1'b0;
        // Cell (r,c) sits at r*MAX_COLS + c, a concatenation for these sizes
        cell_req.we    = 1'b0;
        cell_req.waddr = {cr, cc};
        cell_req.wdata = char_word;
        cell_req.re    = 1'b0;
        cell_req.raddr = {cy, cx};
        glyph_req.we    = 1'b0;
        glyph_req.waddr = font_addr;
        glyph_req.wdata = font_byte;
        glyph_req.re    = 1'b0;
        glyph_req.raddr = {cell_word[7:0], py_lo_reg};
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (func_t'(func))
                        FN_WRITE_CHAR:
                        begin
                            cell_req.we = 1'b1;
                            if (cc == last_col)
                            begin
                                wr_col_next = '0;
                                wr_row_next = (cr == last_row) ? cr : cr + 1'b1;
                            end
                            else
                            begin
                                wr_col_next = cc + 1'b1;
                                wr_row_next = cr;
                            end
                        end
                        FN_SET_CURSOR:
                        begin
                            wr_row_next = (cursor_row > last_row) ? last_row : cursor_row;
                            wr_col_next = (cursor_col > last_col) ? last_col : cursor_col;
                        end
                        FN_LOAD_FONT:
                        begin
                            glyph_req.we = 1'b1;
                        end
                        default:
                        begin
                            cell_req.re = 1'b1;
                            state_next  = ST_CELL;
                        end
                    endcase
                end
            end
            ST_CELL:
            begin
                glyph_req.re = 1'b1;
                state_next   = ST_GLYPH;
            end
            ST_GLYPH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wr_row_reg <= '0;
            wr_col_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            wr_row_reg <= wr_row_next;
            wr_col_reg <= wr_col_next;
        end
    end

    // Capture the pixel details of a render
    always_ff @(posedge clk)
    begin
        if (accept && (func_t'(func) == FN_RENDER))
        begin
            px_lo_reg <= pixel_x[LINE_W-1:0];
            py_lo_reg <= pixel_y[LINE_W-1:0];
            cur_reg   <= cursor_on;
            grid_reg  <= (cx <= last_col) && (cy <= last_row);
        end
    end

    // Pick the glyph bit, leftmost pixel from the top bit
    assign glyph_bit = glyph_line[LINE_W'(GLYPH_SIZE - 1) - px_lo_reg] ^ cur_reg;
    assign colour    = !grid_reg ? 4'd0 : (glyph_bit ? cell_word[11:8] : cell_word[15:12]);

    tcr_cell_store u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cell_req),
        .rdata (cell_word),
        .busy  (clearing)
    );

    tcr_glyph_store u_glyph (
        .clk   (clk),
        .req   (glyph_req),
        .rdata (glyph_line)
    );

    tcr_pixel_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .colour    (colour),
        .out_stall (out_stall),
        .free      (out_free),
        .out_valid (out_valid),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

endmodule

/* rtl/tcr_checker.sv */
// Port-level assertions for the text mode renderer, bound to the top level.
module tcr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  func,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  red,
    input logic [7:0]  green,
    input logic [7:0]  blue
);
    import tcr_pkg::*;

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(red) && $stable(green)
            && $stable(blue))
        else $error("result word changed while stalled");

    // A render blocks the input in the following cycle
    a_render_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (func == FN_RENDER) |=> in_stall)
        else $error("input accepted during a render");

    // Items other than render make no result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (func != FN_RENDER) && !out_valid |=> !out_valid)
        else $error("result word without a render");

    // A new result only appears at the end of a render
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result word appeared while input was open");

endmodule

bind text_mode_character_renderer_core tcr_checker u_tcr_checker (.*);
